// File: sv/ir_uart_carrier_transmitter_macros.svh
// ----------------------------------------------------------------------------
// IR UART carrier transmitter assertion macros
// Concurrent assertion helpers shared by the RTL of the transmitter.
// ----------------------------------------------------------------------------
`ifndef IR_UART_CARRIER_TRANSMITTER_MACROS_SVH
`define IR_UART_CARRIER_TRANSMITTER_MACROS_SVH

`ifndef SYNTHESIS

`define IUCT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expression does not hold");

`define IUCT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

`else

`define IUCT_ASSERT_ALWAYS(label, clk, rst, expr)

`define IUCT_ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/iuct_pkg.sv
// ----------------------------------------------------------------------------
// IR UART carrier transmitter package
// Payload types, request codes, register indexes and reset values of the
// transmitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iuct_pkg;

   localparam int DefFifoDepth = 64;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam int CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CSR_IDLE_HIGH      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CARRIER_CYCLES = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_PERIOD    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_STOP1_UNIT     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_STOP2_UNIT     = 3'd4;

   localparam logic [7:0] RST_CARRIER_CYCLES = 8'd60;
   localparam logic [7:0] RST_HALF_PERIOD    = 8'd13;
   localparam logic [7:0] RST_STOP1_UNIT     = 8'd27;
   localparam logic [7:0] RST_STOP2_UNIT     = 8'd14;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       ir_pin;
      logic       write_accepted;
      logic [6:0] fifo_count;
      logic       busy_res;
   } rsp_type;

endpackage

// File: sv/ir_uart_carrier_transmitter.sv
// ----------------------------------------------------------------------------
// IR UART carrier transmitter
// Queues bytes in a memory FIFO and sends them as carrier-modulated UART
// frames, one tick or one byte write per request.
// ----------------------------------------------------------------------------
// The block takes one request every clock cycle while req_stall is low and
// returns one response per request through a two-entry output buffer. A tick
// request advances the frame timing; a write request queues a byte unless the
// queue is full. The queue lives in a single memory with one write and one
// registered read port; the byte at the head is read when a frame starts and
// is shifted out from the following cycle on, so a frame may start on any tick.
`timescale 1ns / 1ps

`include "ir_uart_carrier_transmitter_macros.svh"

module ir_uart_carrier_transmitter #(
   parameter int FIFO_DEPTH = iuct_pkg::DefFifoDepth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  iuct_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output iuct_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [iuct_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [7:0]                            csr_data
);

   import iuct_pkg::*;

   localparam int PtrWidth = $clog2(FIFO_DEPTH);
   localparam int CntWidth = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_DATA  = 3'd2;
   localparam logic [2:0] PH_STOP1 = 3'd3;
   localparam logic [2:0] PH_STOP2 = 3'd4;

   logic [7:0] queue_mem [FIFO_DEPTH];
   logic [7:0] rdata_ff;

   logic                idle_high_ff, idle_high_in;
   logic [7:0]          carrier_ff, carrier_in;
   logic [7:0]          half_ff, half_in;
   logic [7:0]          stop1_ff, stop1_in;
   logic [7:0]          stop2_ff, stop2_in;

   logic [PtrWidth-1:0] rptr_ff, rptr_in;
   logic [PtrWidth-1:0] wptr_ff, wptr_in;
   logic [CntWidth-1:0] fill_ff, fill_in;
   logic [2:0]          phase_ff, phase_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          shift_ff, shift_in;
   logic                shift_load_ff, shift_load_in;
   logic [7:0]          unit_ff, unit_in;
   logic [7:0]          tick_ff, tick_in;
   logic                pin_ff, pin_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                skid_valid_ff, skid_valid_in;
   rsp_type             skid_data_ff, skid_data_in;

   logic                accept;
   logic                mem_we;
   logic                mem_re;
   logic                accepted;
   logic                do_start;
   logic [7:0]          shift_cur;
   logic [8:0]          unit_res;
   rsp_type             result;

   function automatic logic [8:0] begin_unit(
      input logic [2:0] phase,
      input logic       lsb,
      input logic       pin,
      input logic       idle,
      input logic [7:0] half,
      input logic [7:0] stop1,
      input logic [7:0] stop2
   );
      logic       new_pin;
      logic [7:0] len;
      case (phase)
         PH_START: begin
            new_pin = ~pin;
            len     = half;
         end
         PH_DATA: begin
            new_pin = lsb ? idle : ~pin;
            len     = half;
         end
         PH_STOP1: begin
            new_pin = idle;
            len     = stop1;
         end
         default: begin
            new_pin = idle;
            len     = stop2;
         end
      endcase
      return {new_pin, 8'(len - 8'd1)};
   endfunction

   assign accept    = req_valid & ~req_stall;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign shift_cur = shift_load_ff ? rdata_ff : shift_ff;

   always_comb begin
      rptr_in       = rptr_ff;
      wptr_in       = wptr_ff;
      fill_in       = fill_ff;
      phase_in      = phase_ff;
      bit_in        = bit_ff;
      shift_in      = shift_cur;
      shift_load_in = 1'b0;
      unit_in       = unit_ff;
      tick_in       = tick_ff;
      pin_in        = pin_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      accepted      = 1'b0;
      do_start      = 1'b0;
      unit_res      = '0;

      if (accept) begin
         if (req_data.func == FUNC_WRITE) begin
            if (fill_ff < CntWidth'(FIFO_DEPTH)) begin
               mem_we   = 1'b1;
               wptr_in  = (wptr_ff == PtrWidth'(FIFO_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
               fill_in  = fill_ff + 1'b1;
               accepted = 1'b1;
            end
         end else begin
            if (phase_ff == PH_IDLE || phase_ff > PH_STOP2) begin
               phase_in = PH_IDLE;
               do_start = 1'b1;
            end else if (tick_ff != 8'd0) begin
               tick_in = tick_ff - 8'd1;
            end else if (8'(unit_ff + 8'd1) != carrier_ff) begin
               unit_in  = unit_ff + 8'd1;
               unit_res = begin_unit(phase_ff, shift_cur[0], pin_ff, idle_high_ff,
                                     half_ff, stop1_ff, stop2_ff);
               {pin_in, tick_in} = unit_res;
            end else begin
               unit_in = 8'd0;
               case (phase_ff)
                  PH_START: begin
                     phase_in = PH_DATA;
                     bit_in   = 3'd0;
                     unit_res = begin_unit(PH_DATA, shift_cur[0], pin_ff, idle_high_ff,
                                           half_ff, stop1_ff, stop2_ff);
                     {pin_in, tick_in} = unit_res;
                  end
                  PH_DATA: begin
                     shift_in = {1'b0, shift_cur[7:1]};
                     if (bit_ff == 3'd7) begin
                        phase_in = PH_STOP1;
                        unit_res = begin_unit(PH_STOP1, 1'b0, pin_ff, idle_high_ff,
                                              half_ff, stop1_ff, stop2_ff);
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        unit_res = begin_unit(PH_DATA, shift_cur[1], pin_ff, idle_high_ff,
                                              half_ff, stop1_ff, stop2_ff);
                     end
                     {pin_in, tick_in} = unit_res;
                  end
                  PH_STOP1: begin
                     phase_in = PH_STOP2;
                     unit_res = begin_unit(PH_STOP2, 1'b0, pin_ff, idle_high_ff,
                                           half_ff, stop1_ff, stop2_ff);
                     {pin_in, tick_in} = unit_res;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     pin_in   = idle_high_ff;
                     do_start = 1'b1;
                  end
               endcase
            end

            if (do_start && fill_ff != '0) begin
               mem_re        = 1'b1;
               rptr_in       = (rptr_ff == PtrWidth'(FIFO_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
               fill_in       = fill_ff - 1'b1;
               phase_in      = PH_START;
               bit_in        = 3'd0;
               unit_in       = 8'd0;
               pin_in        = ~idle_high_ff;
               tick_in       = 8'(half_ff - 8'd1);
               shift_load_in = 1'b1;
            end
         end
      end

      idle_high_in = idle_high_ff;
      carrier_in   = carrier_ff;
      half_in      = half_ff;
      stop1_in     = stop1_ff;
      stop2_in     = stop2_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IDLE_HIGH: begin
               idle_high_in = csr_data[0];
               if (phase_ff == PH_IDLE && !accept) begin
                  pin_in = csr_data[0];
               end
            end
            CSR_CARRIER_CYCLES: carrier_in = csr_data;
            CSR_HALF_PERIOD:    half_in    = csr_data;
            CSR_STOP1_UNIT:     stop1_in   = csr_data;
            CSR_STOP2_UNIT:     stop2_in   = csr_data;
            default: begin
            end
         endcase
      end

      result.ir_pin         = pin_in;
      result.write_accepted = accepted;
      result.fifo_count     = 7'(fill_in);
      result.busy_res       = (phase_in != PH_IDLE);

      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[wptr_ff] <= req_data.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= queue_mem[rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_high_ff  <= 1'b0;
         carrier_ff    <= RST_CARRIER_CYCLES;
         half_ff       <= RST_HALF_PERIOD;
         stop1_ff      <= RST_STOP1_UNIT;
         stop2_ff      <= RST_STOP2_UNIT;
         rptr_ff       <= '0;
         wptr_ff       <= '0;
         fill_ff       <= '0;
         phase_ff      <= PH_IDLE;
         bit_ff        <= 3'd0;
         shift_ff      <= 8'd0;
         shift_load_ff <= 1'b0;
         unit_ff       <= 8'd0;
         tick_ff       <= 8'd0;
         pin_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         idle_high_ff  <= idle_high_in;
         carrier_ff    <= carrier_in;
         half_ff       <= half_in;
         stop1_ff      <= stop1_in;
         stop2_ff      <= stop2_in;
         rptr_ff       <= rptr_in;
         wptr_ff       <= wptr_in;
         fill_ff       <= fill_in;
         phase_ff      <= phase_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         shift_load_ff <= shift_load_in;
         unit_ff       <= unit_in;
         tick_ff       <= tick_in;
         pin_ff        <= pin_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   `IUCT_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= CntWidth'(FIFO_DEPTH))
   `IUCT_ASSERT_IMPLY(a_load_in_start, clock, reset, shift_load_ff, phase_ff == PH_START)
   `IUCT_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `IUCT_ASSERT_IMPLY(a_no_read_and_write, clock, reset, mem_re, !mem_we)

endmodule
